// ----- src/lcdi2c_pkg.sv -----
package lcdi2c_pkg;

    // Opcodes of an input item
    localparam logic [1:0] OP_PRINT   = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_CURSOR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS   = 2'd0;
    localparam logic [1:0] CFG_ROWS      = 2'd1;
    localparam logic [1:0] CFG_BACKLIGHT = 2'd2;
    localparam logic [1:0] CFG_ADDRESS   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [5:0] COLUMNS_RESET   = 6'd16;
    localparam logic [2:0] ROWS_RESET      = 3'd2;
    localparam logic       BACKLIGHT_RESET = 1'b1;
    localparam logic [6:0] ADDRESS_RESET   = 7'd39;

    localparam int unsigned CFG_DATA_W = 7;

    // LCD controller constants
    localparam logic       DDRAM_CMD_BIT = 1'b1;

    typedef struct packed {
        logic [5:0] columns;
        logic [2:0] rows;
        logic       backlight_on;
        logic [6:0] device_address;
    } cfg_t;

    // One LCD byte that becomes a four-byte expander write
    typedef struct packed {
        logic [7:0] data;
        logic       rs;
        logic       bl;
        logic [6:0] addr;
        logic       last;
    } job_t;

    // DDRAM start address of each display row
    function automatic logic [6:0] row_offset(input logic [1:0] row);
        logic [6:0] offs;
        case (row)
            2'd0:    offs = 7'h00;
            2'd1:    offs = 7'h40;
            2'd2:    offs = 7'h14;
            2'd3:    offs = 7'h54;
            default: offs = 7'h00;
        endcase
        return offs;
    endfunction

endpackage

// ----- src/lcdi2c_front.sv -----
module lcdi2c_front
    import lcdi2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] opcode,
    input  logic [7:0] value,
    input  logic [5:0] cursor_column,
    input  logic [1:0] cursor_row,
    input  logic       string_start,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_data
);

    logic [5:0] print_column_reg, print_column_next;
    logic [1:0] print_row_reg, print_row_next;
    logic       pending_valid_reg, pending_valid_next;
    job_t       pending_reg, pending_next;

    logic       accept;
    logic [5:0] col_cur;
    logic [1:0] row_cur;
    logic [2:0] eff_rows;
    logic       wrap;
    logic [2:0] row_inc;
    logic [1:0] wrap_row;
    logic [1:0] clamp_row;
    logic [6:0] cursor_addr;
    logic       first_valid;
    job_t       first_job;

    assign full   = pending_valid_reg || q_full;
    assign accept = push && !full;

    always_comb
    begin
        col_cur = string_start ? 6'd0 : print_column_reg;
        row_cur = string_start ? 2'd0 : print_row_reg;

        if (cfg.rows == 3'd0)
            eff_rows = 3'd1;
        else if (cfg.rows > 3'd4)
            eff_rows = 3'd4;
        else
            eff_rows = cfg.rows;

        wrap     = (col_cur >= cfg.columns);
        row_inc  = {1'b0, row_cur} + 3'd1;
        wrap_row = (row_inc >= eff_rows) ? 2'd0 : row_inc[1:0];

        if ({1'b0, cursor_row} >= eff_rows)
            clamp_row = 2'(eff_rows - 3'd1);
        else
            clamp_row = cursor_row;
        cursor_addr = {1'b0, cursor_column} + row_offset(clamp_row);
    end

    always_comb
    begin
        first_valid        = 1'b0;
        first_job.data     = value;
        first_job.rs       = 1'b0;
        first_job.bl       = cfg.backlight_on;
        first_job.addr     = cfg.device_address;
        first_job.last     = 1'b1;
        pending_next       = pending_reg;
        pending_valid_next = pending_valid_reg;
        print_column_next  = print_column_reg;
        print_row_next     = print_row_reg;

        // drain the held character once the queue has room
        if (pending_valid_reg && !q_full)
            pending_valid_next = 1'b0;

        if (accept)
        begin
            case (opcode)
                OP_PRINT:
                begin
                    first_valid = 1'b1;
                    if (wrap)
                    begin
                        first_job.data      = {DDRAM_CMD_BIT, row_offset(wrap_row)};
                        first_job.last      = 1'b0;
                        pending_next        = first_job;
                        pending_next.data   = value;
                        pending_next.rs     = 1'b1;
                        pending_next.last   = 1'b1;
                        pending_valid_next  = 1'b1;
                        print_column_next   = 6'd1;
                        print_row_next      = wrap_row;
                    end
                    else
                    begin
                        first_job.rs      = 1'b1;
                        print_column_next = col_cur + 6'd1;
                        print_row_next    = row_cur;
                    end
                end
                OP_COMMAND:
                    first_valid = 1'b1;
                OP_CURSOR:
                begin
                    first_valid    = 1'b1;
                    first_job.data = {DDRAM_CMD_BIT, cursor_addr};
                end
                default:
                    first_valid = 1'b0;
            endcase
        end
    end

    assign q_push = pending_valid_reg ? !q_full : (accept && first_valid);
    assign q_data = pending_valid_reg ? pending_reg : first_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            print_column_reg  <= '0;
            print_row_reg     <= '0;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            print_column_reg  <= print_column_next;
            print_row_reg     <= print_row_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_reg <= pending_next;
    end

endmodule

// ----- src/lcdi2c_queue.sv -----
module lcdi2c_queue
    import lcdi2c_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output job_t rd_data,
    output logic q_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- src/lcdi2c_back.sv -----
module lcdi2c_back
    import lcdi2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       rd_data,
    input  logic       q_empty,
    output logic       rd_en,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] bus_byte,
    output logic [6:0] target_address,
    output logic       transfer_end,
    output logic       last
);

    logic       busy_reg, busy_next;
    logic [1:0] phase_reg, phase_next;
    job_t       job_reg, job_next;

    logic       advance;
    logic       load;
    logic [3:0] nibble;

    assign advance = pop && busy_reg;
    assign load    = !busy_reg || (advance && phase_reg == 2'd3);
    assign rd_en   = load && !q_empty;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        job_next   = job_reg;
        if (load)
        begin
            busy_next  = !q_empty;
            phase_next = 2'd0;
            job_next   = rd_data;
        end
        else if (advance)
            phase_next = phase_reg + 2'd1;
    end

    // high nibble first, each one strobed with enable high then low
    assign nibble         = phase_reg[1] ? job_reg.data[3:0] : job_reg.data[7:4];
    assign bus_byte       = {nibble, job_reg.bl, !phase_reg[0], 1'b0, job_reg.rs};
    assign target_address = job_reg.addr;
    assign transfer_end   = (phase_reg == 2'd3);
    assign last           = job_reg.last && (phase_reg == 2'd3);
    assign empty          = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// ----- src/char_lcd_i2c_nibble_formatter.sv -----
// An accepted item is written into the job queue and then loaded into the serializer's job
// register when the serializer is idle, which puts its first result byte on the output ports.
// The nibble serializer turns each LCD byte into four output bytes; an item yields one LCD
// byte, or two for a print that wraps to the next row; opcode three yields nothing.
// The input side takes a new item each cycle while the job queue has room; a wrapping print
// holds full high while its second job waits to enter the queue.
// Reset (rst_n low, asynchronous): configuration returns to 16 columns, 2 rows, backlight
// on, address 39; print position goes to column 0, row 0; queue and serializer empty.
module char_lcd_i2c_nibble_formatter
    import lcdi2c_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input item channel
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            opcode,
    input  logic [7:0]            value,
    input  logic [5:0]            cursor_column,
    input  logic [1:0]            cursor_row,
    input  logic                  string_start,
    // result channel
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            bus_byte,
    output logic [6:0]            target_address,
    output logic                  transfer_end,
    output logic                  last,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    logic q_full, q_empty, q_push, q_pop;
    job_t q_wr_data, q_rd_data;

    // Configuration registers; to be written only while the block is idle, a rule on the user
    // that the block itself does not enforce, so the front end samples them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns        <= COLUMNS_RESET;
            cfg_reg.rows           <= ROWS_RESET;
            cfg_reg.backlight_on   <= BACKLIGHT_RESET;
            cfg_reg.device_address <= ADDRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COLUMNS:   cfg_reg.columns        <= cfg_data[5:0];
                CFG_ROWS:      cfg_reg.rows           <= cfg_data[2:0];
                CFG_BACKLIGHT: cfg_reg.backlight_on   <= cfg_data[0];
                CFG_ADDRESS:   cfg_reg.device_address <= cfg_data[6:0];
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front end: classify each transaction, track the print position and
    // turn it into at most two LCD-byte jobs (cursor move ahead of a wrapped
    // character).
    lcdi2c_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .value         (value),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .string_start  (string_start),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wr_data)
    );

    // Job queue: decouple classification from the slow byte serializer.
    lcdi2c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_empty (q_empty)
    );

    // Back end: expand each job into four expander bytes, hold each one on
    // the result ports until it is popped.
    lcdi2c_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .rd_data        (q_rd_data),
        .q_empty        (q_empty),
        .rd_en          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .bus_byte       (bus_byte),
        .target_address (target_address),
        .transfer_end   (transfer_end),
        .last           (last)
    );

endmodule
